// ===== hdl/qprt_pkg.sv =====
// Shared constants for the quaternion point rotate and translate block.
`default_nettype none

package qprt_pkg;

    localparam int QUAT_BITS      = 32;
    localparam int COORD_BITS_DEF = 32;
    localparam int QUAT_FRAC_DEF  = 30;

    // Coefficients are split at this bit for the partial products.
    localparam int K_SPLIT = 32;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_QUAT_W  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUAT_X  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUAT_Y  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUAT_Z  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_Y = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_Z = 3'd6;

    // Unit scalar part after reset.
    localparam logic signed [QUAT_BITS-1:0] QUAT_W_RESET = 32'sh4000_0000;

    // The other two mode codes both rotate.
    localparam logic [1:0] MODE_SHIFT   = 2'd1;
    localparam logic [1:0] MODE_REVERSE = 2'd2;

    // Positions of the quaternion component products.
    localparam int P_AB = 0;
    localparam int P_AC = 1;
    localparam int P_AD = 2;
    localparam int P_BB = 3;
    localparam int P_BC = 4;
    localparam int P_BD = 5;
    localparam int P_CC = 6;
    localparam int P_CD = 7;
    localparam int P_DD = 8;
    localparam int NUM_PROD = 9;

endpackage

`default_nettype wire

// ===== hdl/quaternion_point_rotate_translate.sv =====
// Six-stage pipelined quaternion rotation of Q16.16 points with optional translation.
//
// Input channel: i_valid with o_stall; a point transfers on a rising edge where i_valid
// is high and o_stall is low. Output channel: o_valid with i_stall in the same way.
// Each point gives exactly one result, in order, with a saturation flag.
// A point passes through six register stages on its way to o_valid, and one point can
// be taken in every cycle while i_stall is low, so throughput is one result per clock.
// The stages are: component products, coefficient sums, split partial products,
// row sums, rounding and finally translation with saturation; each holds at most one
// layer of multipliers or one wide addition.
// When the receiver stalls, the result waits in the output register and the earlier
// stages keep filling any empty slots; the input is stalled only once every stage
// holds a point. Nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and sets the quaternion to the
// identity and the translation to zero. Configuration writes take effect at once and
// are meant to be made while no point is in flight.
`default_nettype none

module quaternion_point_rotate_translate #(
    parameter int COORD_BITS     = qprt_pkg::COORD_BITS_DEF,
    parameter int QUAT_FRAC_BITS = qprt_pkg::QUAT_FRAC_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [qprt_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [((COORD_BITS > qprt_pkg::QUAT_BITS) ? COORD_BITS
                   : qprt_pkg::QUAT_BITS)-1:0]      i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [1:0]                              i_mode,
    input  logic signed [COORD_BITS-1:0]            i_point_x,
    input  logic signed [COORD_BITS-1:0]            i_point_y,
    input  logic signed [COORD_BITS-1:0]            i_point_z,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [COORD_BITS-1:0]            o_out_x,
    output logic signed [COORD_BITS-1:0]            o_out_y,
    output logic signed [COORD_BITS-1:0]            o_out_z,
    output logic                                    o_overflow
);

    import qprt_pkg::*;

    localparam int QW    = QUAT_BITS;
    localparam int KW    = 2 * QW + 1;
    localparam int KHW   = KW - K_SPLIT;
    localparam int OPW   = (KHW > K_SPLIT + 1) ? KHW : K_SPLIT + 1;
    localparam int PW    = OPW + COORD_BITS;
    localparam int SW    = PW + 2;
    localparam int AW    = SW + K_SPLIT + 1;
    localparam int SHR   = 2 * QUAT_FRAC_BITS - 1;
    localparam int RDW   = AW - SHR;
    localparam int TW    = RDW + 2;
    localparam int NSTG  = 6;

    localparam logic signed [AW-1:0] RND = AW'(1) << (SHR - 1);
    localparam logic signed [COORD_BITS-1:0] MAXC = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] MINC = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Configuration registers.
    logic signed [QW-1:0]         r_quat_w;
    logic signed [QW-1:0]         r_quat_x;
    logic signed [QW-1:0]         r_quat_y;
    logic signed [QW-1:0]         r_quat_z;
    logic signed [COORD_BITS-1:0] r_shift [3];

    // Pipeline control.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_en;

    // Stage registers and their next values.
    logic signed [2*QW-1:0]       r_s1_p [NUM_PROD];
    logic signed [2*QW-1:0]       n_s1_p [NUM_PROD];
    logic [1:0]                   r_s1_mode;
    logic signed [COORD_BITS-1:0] r_s1_v [3];

    logic signed [KW-1:0]         r_s2_k [3][3];
    logic signed [KW-1:0]         n_s2_k [3][3];
    logic                         r_s2_trn;
    logic signed [COORD_BITS-1:0] r_s2_v [3];

    logic signed [PW-1:0]         r_s3_hi [3][3];
    logic signed [PW-1:0]         r_s3_lo [3][3];
    logic signed [PW-1:0]         n_s3_hi [3][3];
    logic signed [PW-1:0]         n_s3_lo [3][3];
    logic                         r_s3_trn;
    logic signed [COORD_BITS-1:0] r_s3_v [3];

    logic signed [SW-1:0]         r_s4_hs [3];
    logic signed [SW-1:0]         r_s4_ls [3];
    logic signed [SW-1:0]         n_s4_hs [3];
    logic signed [SW-1:0]         n_s4_ls [3];
    logic                         r_s4_trn;
    logic signed [COORD_BITS-1:0] r_s4_v [3];

    logic signed [AW-1:0]         s5_full [3];
    logic signed [RDW-1:0]        r_s5_rnd [3];
    logic signed [RDW-1:0]        n_s5_rnd [3];
    logic                         r_s5_trn;
    logic signed [COORD_BITS-1:0] r_s5_v [3];

    logic signed [TW-1:0]         s6_tot [3];
    logic signed [COORD_BITS-1:0] r_s6_out [3];
    logic signed [COORD_BITS-1:0] n_s6_out [3];
    logic                         r_s6_ovf;
    logic                         n_s6_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat_w   <= QUAT_W_RESET;
            r_quat_x   <= '0;
            r_quat_y   <= '0;
            r_quat_z   <= '0;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_QUAT_W:  r_quat_w   <= i_cfg_data[QW-1:0];
                REG_QUAT_X:  r_quat_x   <= i_cfg_data[QW-1:0];
                REG_QUAT_Y:  r_quat_y   <= i_cfg_data[QW-1:0];
                REG_QUAT_Z:  r_quat_z   <= i_cfg_data[QW-1:0];
                REG_SHIFT_X: r_shift[0] <= i_cfg_data[COORD_BITS-1:0];
                REG_SHIFT_Y: r_shift[1] <= i_cfg_data[COORD_BITS-1:0];
                REG_SHIFT_Z: r_shift[2] <= i_cfg_data[COORD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    assign stg_en[5] = !r_vld[5] || !i_stall;
    assign stg_en[4] = !r_vld[4] || stg_en[5];
    assign stg_en[3] = !r_vld[3] || stg_en[4];
    assign stg_en[2] = !r_vld[2] || stg_en[3];
    assign stg_en[1] = !r_vld[1] || stg_en[2];
    assign stg_en[0] = !r_vld[0] || stg_en[1];
    assign o_stall   = !stg_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) r_vld[0] <= i_valid;
            if (stg_en[1]) r_vld[1] <= r_vld[0];
            if (stg_en[2]) r_vld[2] <= r_vld[1];
            if (stg_en[3]) r_vld[3] <= r_vld[2];
            if (stg_en[4]) r_vld[4] <= r_vld[3];
            if (stg_en[5]) r_vld[5] <= r_vld[4];
        end
    end

    // Stage one: quaternion component products.
    always_comb begin
        n_s1_p[P_AB] = (2*QW)'(r_quat_w) * (2*QW)'(r_quat_x);
        n_s1_p[P_AC] = (2*QW)'(r_quat_w) * (2*QW)'(r_quat_y);
        n_s1_p[P_AD] = (2*QW)'(r_quat_w) * (2*QW)'(r_quat_z);
        n_s1_p[P_BB] = (2*QW)'(r_quat_x) * (2*QW)'(r_quat_x);
        n_s1_p[P_BC] = (2*QW)'(r_quat_x) * (2*QW)'(r_quat_y);
        n_s1_p[P_BD] = (2*QW)'(r_quat_x) * (2*QW)'(r_quat_z);
        n_s1_p[P_CC] = (2*QW)'(r_quat_y) * (2*QW)'(r_quat_y);
        n_s1_p[P_CD] = (2*QW)'(r_quat_y) * (2*QW)'(r_quat_z);
        n_s1_p[P_DD] = (2*QW)'(r_quat_z) * (2*QW)'(r_quat_z);
    end

    // Stage two: rotation matrix coefficients; reverse rotation flips the scalar terms.
    always_comb begin
        logic                 rev;
        logic signed [KW-1:0] ab;
        logic signed [KW-1:0] ac;
        logic signed [KW-1:0] ad;
        logic signed [KW-1:0] bb;
        logic signed [KW-1:0] bc;
        logic signed [KW-1:0] bd;
        logic signed [KW-1:0] cc;
        logic signed [KW-1:0] cd;
        logic signed [KW-1:0] dd;
        rev = (r_s1_mode == MODE_REVERSE);
        ab  = rev ? -KW'(r_s1_p[P_AB]) : KW'(r_s1_p[P_AB]);
        ac  = rev ? -KW'(r_s1_p[P_AC]) : KW'(r_s1_p[P_AC]);
        ad  = rev ? -KW'(r_s1_p[P_AD]) : KW'(r_s1_p[P_AD]);
        bb  = KW'(r_s1_p[P_BB]);
        bc  = KW'(r_s1_p[P_BC]);
        bd  = KW'(r_s1_p[P_BD]);
        cc  = KW'(r_s1_p[P_CC]);
        cd  = KW'(r_s1_p[P_CD]);
        dd  = KW'(r_s1_p[P_DD]);
        n_s2_k[0][0] = -(cc + dd);
        n_s2_k[0][1] = bc - ad;
        n_s2_k[0][2] = ac + bd;
        n_s2_k[1][0] = ad + bc;
        n_s2_k[1][1] = -(bb + dd);
        n_s2_k[1][2] = cd - ab;
        n_s2_k[2][0] = bd - ac;
        n_s2_k[2][1] = ab + cd;
        n_s2_k[2][2] = -(bb + cc);
    end

    // Stage three: each coefficient times its coordinate as an upper and a lower part.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_s3_hi[i][j] = PW'($signed(r_s2_k[i][j][KW-1:K_SPLIT]))
                              * PW'(r_s2_v[j]);
                n_s3_lo[i][j] = PW'($signed({1'b0, r_s2_k[i][j][K_SPLIT-1:0]}))
                              * PW'(r_s2_v[j]);
            end
        end
    end

    // Stage four: row sums of the upper and the lower parts.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s4_hs[i] = SW'(r_s3_hi[i][0]) + SW'(r_s3_hi[i][1]) + SW'(r_s3_hi[i][2]);
            n_s4_ls[i] = SW'(r_s3_lo[i][0]) + SW'(r_s3_lo[i][1]) + SW'(r_s3_lo[i][2]);
        end
    end

    // Stage five: join the parts, double and round to nearest, ties upwards.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s5_full[i]  = (AW'(r_s4_hs[i]) <<< K_SPLIT) + AW'(r_s4_ls[i]) + RND;
            n_s5_rnd[i] = s5_full[i][AW-1:SHR];
        end
    end

    // Stage six: add the point and, in shift mode, the translation, then saturate.
    always_comb begin
        logic signed [COORD_BITS-1:0]   add_val;
        logic [TW-COORD_BITS:0]         top;
        n_s6_ovf = 1'b0;
        add_val  = '0;
        top      = '0;
        for (int i = 0; i < 3; i++) begin
            add_val   = r_s5_trn ? r_shift[i] : '0;
            s6_tot[i] = TW'(r_s5_rnd[i]) + TW'(r_s5_v[i]) + TW'(add_val);
            top       = s6_tot[i][TW-1:COORD_BITS-1];
            if ((&top) || !(|top)) begin
                n_s6_out[i] = s6_tot[i][COORD_BITS-1:0];
            end else begin
                n_s6_out[i] = s6_tot[i][TW-1] ? MINC : MAXC;
                n_s6_ovf    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s1_p    <= n_s1_p;
            r_s1_mode <= i_mode;
            r_s1_v[0] <= i_point_x;
            r_s1_v[1] <= i_point_y;
            r_s1_v[2] <= i_point_z;
        end
        if (stg_en[1]) begin
            r_s2_k   <= n_s2_k;
            r_s2_trn <= (r_s1_mode == MODE_SHIFT);
            r_s2_v   <= r_s1_v;
        end
        if (stg_en[2]) begin
            r_s3_hi  <= n_s3_hi;
            r_s3_lo  <= n_s3_lo;
            r_s3_trn <= r_s2_trn;
            r_s3_v   <= r_s2_v;
        end
        if (stg_en[3]) begin
            r_s4_hs  <= n_s4_hs;
            r_s4_ls  <= n_s4_ls;
            r_s4_trn <= r_s3_trn;
            r_s4_v   <= r_s3_v;
        end
        if (stg_en[4]) begin
            r_s5_rnd <= n_s5_rnd;
            r_s5_trn <= r_s4_trn;
            r_s5_v   <= r_s4_v;
        end
        if (stg_en[5]) begin
            r_s6_out <= n_s6_out;
            r_s6_ovf <= n_s6_ovf;
        end
    end

    assign o_valid    = r_vld[NSTG-1];
    assign o_out_x    = r_s6_out[0];
    assign o_out_y    = r_s6_out[1];
    assign o_out_z    = r_s6_out[2];
    assign o_overflow = r_s6_ovf;

    // An empty output register means the whole pipeline can move.
    a_empty_out_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NSTG-1] |-> !o_stall)
        else $error("input stalled while the output register is empty");

    // The input is held off only when every stage holds a point.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld) && i_stall)
        else $error("input stalled with a free slot in the pipeline");

    // An accepted point occupies the first stage in the next cycle.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted point missing from the first stage");

endmodule

`default_nettype wire
